// File: hdl/ranked_sorted_set_assert.svh
// Assertion helpers for the checker file.
`ifndef RANKED_SORTED_SET_ASSERT_SVH
`define RANKED_SORTED_SET_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define RSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Condition holds in the cycle after the trigger.
`define RSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: hdl/rss_pkg.sv
package rss_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 17;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int RANK_W  = 6;
  localparam int PLACE_W = 6;
  localparam int CMP_W   = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_REMOVED  = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic             ins;
    logic             rem;
    key_t             key;
    logic [CMP_W-1:0] rank;
    logic [CMP_W-1:0] fill;
  } ctl_t;

endpackage

// File: hdl/rss_in_if.sv
interface rss_in_if;
  import rss_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  key_t                key_value;
  logic [RANK_W-1:0]   rank;

  modport source (output valid, cmd, key_value, rank, input ready);
  modport sink   (input valid, cmd, key_value, rank, output ready);
endinterface

// File: hdl/rss_out_if.sv
interface rss_out_if;
  import rss_pkg::*;

  logic                valid;
  logic                ready;
  logic [PLACE_W-1:0]  place;
  logic [1:0]          status;

  modport source (output valid, place, status, input ready);
  modport sink   (input valid, place, status, output ready);
endinterface

// File: hdl/ranked_sorted_set.sv
// Sorted key store, largest key at position 0, held in a chain of cells.
// in_chan carries a command: insert key_value, or remove the entry at rank.
// out_chan returns one result per command: place and status
// (inserted, removed, remove out of range, store full).
// An insert goes behind every strictly greater key; place is the number of
// such keys. A remove closes the gap behind it.
// Timing: a command is transferred and, at that same edge, every cell
// compares its key with the new one and shifts. The landing cell and the
// status are registered; in S_RESULT the landing cell is encoded into
// place and loaded into the output register with the status, and only
// then is a new command taken. The one-hot encode of the landing cell
// works on the registered landing vector.
// If the receiver stalls, the result waits in the output register and the
// next command is still taken; its own result then waits for the slot.
// Reset (rst_n low, synchronous) empties the store and drops any pending
// result; no clearing pass is needed.
module ranked_sorted_set (
  input logic      clk,
  input logic      rst_n,
  rss_in_if.sink   in_chan,
  rss_out_if.source out_chan
);
  import rss_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [1:0]       status_r;
  logic [CAPACITY-1:0] land_r;

  logic               out_valid_r, out_valid_nxt;
  logic [PLACE_W-1:0] out_place_r;
  logic [1:0]         out_status_r;
  logic               load_out;

  logic accept, full, rank_ok;
  ctl_t ctl;
  logic [CMP_W-1:0] pos;

  key_t keys [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] land;

  assign in_chan.ready   = (state_r == S_IDLE);
  assign accept          = in_chan.valid && in_chan.ready;
  assign full            = (fill_r == CNT_W'(CAPACITY));
  assign rank_ok         = CMP_W'(in_chan.rank) < CMP_W'(fill_r);

  assign ctl.ins  = accept && (in_chan.cmd == CMD_INSERT) && !full;
  assign ctl.rem  = accept && (in_chan.cmd == CMD_REMOVE) && rank_ok;
  assign ctl.key  = in_chan.key_value;
  assign ctl.rank = CMP_W'(in_chan.rank);
  assign ctl.fill = CMP_W'(fill_r);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      key_t pk, nk;
      logic pg;
      if (g == 0) begin : g_head
        assign pk = ctl.key;
        assign pg = 1'b1;
      end else begin : g_body
        assign pk = keys[g-1];
        assign pg = gt[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign nk = keys[g];
      end else begin : g_mid
        assign nk = keys[g+1];
      end
      rss_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .idx      (IDX_W'(g)),
        .prev_key (pk),
        .next_key (nk),
        .prev_gt  (pg),
        .key      (keys[g]),
        .gt       (gt[g]),
        .land     (land[g])
      );
    end
  endgenerate

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.ins) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (ctl.rem) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  // one-hot landing vector to index
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (land_r[i]) begin
        pos = pos | CMP_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      land_r <= land;
      if (in_chan.cmd == CMD_INSERT) begin
        status_r <= full ? STAT_FULL : STAT_INSERTED;
      end else begin
        status_r <= rank_ok ? STAT_REMOVED : STAT_RANGE;
      end
    end
    if (load_out) begin
      out_place_r  <= pos[PLACE_W-1:0];
      out_status_r <= status_r;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.place  = out_place_r;
  assign out_chan.status = out_status_r;
endmodule

// File: hdl/rss_cell.sv
module rss_cell (
  input  logic              clk,
  input  rss_pkg::ctl_t     ctl,
  input  logic [rss_pkg::IDX_W-1:0] idx,
  input  rss_pkg::key_t     prev_key,
  input  rss_pkg::key_t     next_key,
  input  logic              prev_gt,
  output rss_pkg::key_t     key,
  output logic              gt,
  output logic              land
);
  import rss_pkg::*;

  key_t key_r;
  key_t key_nxt;
  logic occ;
  logic [CMP_W-1:0] idx_ext;

  assign idx_ext = CMP_W'(idx);
  assign occ     = idx_ext < ctl.fill;
  assign gt      = occ && (key_r > ctl.key);
  // prev_gt means every cell ahead holds a greater key
  assign land    = ctl.ins && !gt && prev_gt;
  assign key     = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins) begin
      if (!gt) begin
        key_nxt = prev_gt ? ctl.key : prev_key;
      end
    end else if (ctl.rem) begin
      if (idx_ext >= ctl.rank) begin
        key_nxt = next_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end
endmodule

// File: hdl/rss_checker.sv
`include "ranked_sorted_set_assert.svh"

module rss_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rss_pkg::PLACE_W-1:0] out_place,
  input logic [1:0]                 out_status
);
  import rss_pkg::*;

  // one command in flight: no transfer in the cycle after one
  `RSS_ASSERT_NEXT(a_one_per_two, in_valid && in_ready, !in_ready)

  // a waiting result is held
  `RSS_ASSERT_NEXT(a_hold, out_valid && !out_ready,
                   out_valid && $stable(out_place) && $stable(out_status))

  // only an insert that went in reports a place
  `RSS_ASSERT_NOW(a_place_zero, out_valid && (out_status != STAT_INSERTED),
                  out_place == '0)
endmodule

bind ranked_sorted_set rss_checker u_rss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_place  (out_chan.place),
  .out_status (out_chan.status)
);

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rss_pkg::*;

  localparam int   RUN_LIMIT    = 400_000;
  localparam int   CHOKE_CYCLES = 200;
  localparam int   RAND_ITEMS   = 600;
  localparam key_t KEY_MAX      = '1;

  typedef struct packed {
    logic [PLACE_W-1:0] place;
    logic [1:0]         status;
  } result_t;

  // Typed expectation travelling with a transfer; unused when 'fixed' is low.
  typedef struct packed {
    bit      fixed;
    result_t res;
  } note_t;

  typedef struct packed {
    logic              cmd;
    key_t              key;
    logic [RANK_W-1:0] rank;
    bit                fixed;
    logic [PLACE_W-1:0] place;
    logic [1:0]        status;
  } cmd_row_t;

  typedef enum int {MIX_EVEN, MIX_GROW, MIX_SHRINK, MIX_DUPES} mix_t;

  logic clk = 1'b0;
  logic rst_n;

  rss_in_if  in_chan ();
  rss_out_if out_chan ();

  ranked_sorted_set dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted contents of the store, updated on each input transfer.
  key_t    set_keys [CAPACITY];
  int      set_fill = 0;
  // Fill level as seen by the stimulus generator, ahead of the transfers.
  int      gen_fill = 0;
  result_t expected_q [$];
  note_t   note_q [$];
  int      fail_cnt = 0;
  int      cycle_cnt = 0;
  int      rand_sent = 0;
  bit      send_calm = 1'b0;
  bit      recv_calm = 1'b0;
  bit      choke_req = 1'b0;
  bit      choke_done = 1'b0;

  cmd_row_t dir_rows [20] = '{
    '{CMD_REMOVE, 17'h00000, 6'd0,  1'b1, 6'd0, STAT_RANGE},    // empty store
    '{CMD_REMOVE, 17'h1abcd, 6'd63, 1'b1, 6'd0, STAT_RANGE},
    '{CMD_INSERT, 17'h00000, 6'd0,  1'b1, 6'd0, STAT_INSERTED},
    '{CMD_INSERT, KEY_MAX,   6'd0,  1'b1, 6'd0, STAT_INSERTED},
    '{CMD_INSERT, 17'h00000, 6'd63, 1'b0, 6'd0, STAT_INSERTED}, // equal to tail
    '{CMD_INSERT, KEY_MAX,   6'd63, 1'b1, 6'd0, STAT_INSERTED}, // equal to head
    '{CMD_INSERT, 17'h10000, 6'd21, 1'b0, 6'd0, STAT_INSERTED},
    '{CMD_INSERT, 17'h15555, 6'd42, 1'b0, 6'd0, STAT_INSERTED},
    '{CMD_INSERT, 17'h0aaaa, 6'd42, 1'b0, 6'd0, STAT_INSERTED},
    '{CMD_INSERT, 17'h00001, 6'd0,  1'b0, 6'd0, STAT_INSERTED},
    '{CMD_REMOVE, 17'h00000, 6'd63, 1'b1, 6'd0, STAT_RANGE},
    '{CMD_REMOVE, KEY_MAX,   6'd8,  1'b1, 6'd0, STAT_RANGE},    // rank equals count
    '{CMD_REMOVE, 17'h00000, 6'd7,  1'b1, 6'd0, STAT_REMOVED},  // tail entry
    '{CMD_REMOVE, 17'h00000, 6'd0,  1'b1, 6'd0, STAT_REMOVED},  // head entry
    '{CMD_REMOVE, 17'h15555, 6'd3,  1'b0, 6'd0, STAT_REMOVED},
    '{CMD_INSERT, 17'h1fffe, 6'd0,  1'b0, 6'd0, STAT_INSERTED},
    '{CMD_INSERT, 17'h00001, 6'd0,  1'b0, 6'd0, STAT_INSERTED},
    '{CMD_INSERT, 17'h0ffff, 6'd0,  1'b0, 6'd0, STAT_INSERTED},
    '{CMD_REMOVE, 17'h00000, 6'd21, 1'b1, 6'd0, STAT_RANGE},
    '{CMD_REMOVE, 17'h00000, 6'd1,  1'b0, 6'd0, STAT_REMOVED}
  };

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic result_t apply_cmd(input logic cmd, input key_t key,
                                        input logic [RANK_W-1:0] rank);
    result_t res;
    int      above;
    int      i;
    res.place = '0;
    if (cmd == CMD_INSERT) begin
      if (set_fill >= CAPACITY) begin
        res.status = STAT_FULL;
      end else begin
        above = 0;
        for (i = 0; i < set_fill; i++)
          if (set_keys[i] > key) above++;
        for (i = set_fill; i > above; i--)
          set_keys[i] = set_keys[i-1];
        set_keys[above] = key;
        set_fill++;
        res.place  = above[PLACE_W-1:0];
        res.status = STAT_INSERTED;
      end
    end else begin
      if (int'(rank) >= set_fill) begin
        res.status = STAT_RANGE;
      end else begin
        for (i = int'(rank); i + 1 < set_fill; i++)
          set_keys[i] = set_keys[i+1];
        set_fill--;
        res.status = STAT_REMOVED;
      end
    end
    return res;
  endfunction

  function automatic void track_fill(input logic cmd, input logic [RANK_W-1:0] rank);
    if (cmd == CMD_INSERT) begin
      if (gen_fill < CAPACITY) gen_fill++;
    end else if (int'(rank) < gen_fill) begin
      gen_fill--;
    end
  endfunction

  task automatic send_item(input logic cmd, input key_t key, input logic [RANK_W-1:0] rank,
                           input note_t note);
    int gap;
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    track_fill(cmd, rank);
    note_q = {note_q, note};
    in_chan.cmd       = cmd;
    in_chan.key_value = key;
    in_chan.rank      = rank;
    in_chan.valid     = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  function automatic logic pick_cmd(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   return (r < 80) ? CMD_INSERT : CMD_REMOVE;
      MIX_SHRINK: return (r < 25) ? CMD_INSERT : CMD_REMOVE;
      MIX_DUPES:  return (r < 55) ? CMD_INSERT : CMD_REMOVE;
      default:    return (r < 50) ? CMD_INSERT : CMD_REMOVE;
    endcase
  endfunction

  task automatic send_rand(input logic cmd, input mix_t mix);
    key_t              key;
    logic [RANK_W-1:0] rank;
    int                r;
    r = $urandom_range(0, 99);
    if (mix == MIX_DUPES) begin
      case ($urandom_range(0, 3))
        0:       key = '0;
        1:       key = KEY_MAX;
        2:       key = 17'h00400;
        default: key = 17'h10001;
      endcase
    end else if (r < 5) begin
      key = '0;
    end else if (r < 10) begin
      key = KEY_MAX;
    end else begin
      key = key_t'($urandom);
    end
    // Removes mostly hit a stored entry, the rest land anywhere.
    r = $urandom_range(0, 99);
    if (gen_fill > 0 && r < 70)
      rank = RANK_W'($urandom_range(0, gen_fill - 1));
    else if (gen_fill > 0 && r < 80)
      rank = RANK_W'(gen_fill - 1);
    else
      rank = RANK_W'($urandom_range(0, 63));
    send_item(cmd, key, rank, '0);
    rand_sent++;
  endtask

  // Result checker: compare the oldest expectation, then log a new transfer.
  always @(posedge clk) begin : watch
    result_t want;
    result_t pred;
    note_t   note;
    if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: place %0d status %0d", out_chan.place, out_chan.status);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (out_chan.place !== want.place) begin
          $error("place: expected %0d, actual %0d", want.place, out_chan.place);
          fail_cnt++;
        end
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_chan.status);
          fail_cnt++;
        end
      end
    end
    if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) begin
      note = note_q.pop_front();
      pred = apply_cmd(in_chan.cmd, in_chan.key_value, in_chan.rank);
      expected_q = {expected_q, (note.fixed ? note.res : pred)};
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_req && !choke_done) begin
        // long hold-off so the block backs up and stalls its input
        out_chan.ready = 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
        choke_done = 1'b1;
      end else if (stall_left > 0) begin
        out_chan.ready = 1'b0;
        stall_left--;
      end else begin
        out_chan.ready = 1'b1;
        stall_left = recv_calm ? 0 : pick_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int   span;
    mix_t mix;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.cmd       = CMD_INSERT;
    in_chan.key_value = '0;
    in_chan.rank      = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].rank,
                '{dir_rows[i].fixed, '{dir_rows[i].place, dir_rows[i].status}});

    // Fill to capacity, back-to-back while the receiver holds off,
    // then a few inserts that must be rejected as full.
    send_calm = 1'b1;
    choke_req = 1'b1;
    while (gen_fill < CAPACITY) send_rand(CMD_INSERT, MIX_EVEN);
    send_calm = 1'b0;
    repeat (4) send_rand(CMD_INSERT, MIX_EVEN);
    // Drain to empty, then removes from an empty store.
    while (gen_fill > 0) send_rand(CMD_REMOVE, MIX_EVEN);
    repeat (3) send_rand(CMD_REMOVE, MIX_EVEN);

    while (rand_sent < RAND_ITEMS) begin
      mix       = mix_t'($urandom_range(0, 3));
      span      = $urandom_range(30, 80);
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      repeat (span) send_rand(pick_cmd(mix), mix);
    end
    in_chan.valid = 1'b0;

    while (expected_q.size() != 0 || note_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
